>>> rtl/core/mtlt_pkg.sv
package mtlt_pkg;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       line_end;
   } req_item_type;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] out_byte;
      logic       token_start;
      logic [3:0] error_code;
      logic       last_of_item;
   } rsp_item_type;

   typedef enum logic [3:0] {
      PH_START        = 4'd0,
      PH_NAME         = 4'd1,
      PH_AFTER_NAME   = 4'd2,
      PH_LABEL_FIRST  = 4'd3,
      PH_LABEL_NAME   = 4'd4,
      PH_WAIT_EQ      = 4'd5,
      PH_WAIT_QUOTE   = 4'd6,
      PH_VALUE        = 4'd7,
      PH_AFTER_VALUE  = 4'd8,
      PH_SAMPLE_FIRST = 4'd9,
      PH_SAMPLE_IN    = 4'd10,
      PH_TS_WAIT      = 4'd11,
      PH_TS_IN        = 4'd12,
      PH_DONE         = 4'd13,
      PH_ERROR        = 4'd14
   } phase_type;

   localparam logic [2:0] KIND_NAME   = 3'd0;
   localparam logic [2:0] KIND_LABEL  = 3'd1;
   localparam logic [2:0] KIND_VALUE  = 3'd2;
   localparam logic [2:0] KIND_SAMPLE = 3'd3;
   localparam logic [2:0] KIND_TS     = 3'd4;
   localparam logic [2:0] KIND_STATUS = 3'd5;

   localparam logic [3:0] ERR_OK          = 4'd0;
   localparam logic [3:0] ERR_NO_NAME     = 4'd1;
   localparam logic [3:0] ERR_END_NAME    = 4'd2;
   localparam logic [3:0] ERR_LABEL_START = 4'd3;
   localparam logic [3:0] ERR_NO_EQ       = 4'd4;
   localparam logic [3:0] ERR_NO_QUOTE    = 4'd5;
   localparam logic [3:0] ERR_END_VALUE   = 4'd6;
   localparam logic [3:0] ERR_AFTER_VALUE = 4'd7;
   localparam logic [3:0] ERR_SAMPLE_CHAR = 4'd8;
   localparam logic [3:0] ERR_NO_SAMPLE   = 4'd9;
   localparam logic [3:0] ERR_TS_CHAR     = 4'd10;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_N      = 8'h6E;

   localparam int unsigned RSP_DEPTH = 8;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_num(input logic [7:0] c);
      logic r;
      case (c)
         8'h2E, 8'h2D, 8'h2B, 8'h65, 8'h45, 8'h49, 8'h4E, 8'h46, 8'h54, 8'h59,
         8'h69, 8'h6E, 8'h66, 8'h74, 8'h79, 8'h58, 8'h78: r = 1'b1;
         default: r = is_digit(c);
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/metric_text_line_tokenizer.sv
// Metric text line tokenizer: takes one ASCII byte per item (or an end-of-line
// item) and returns the bytes of the metric name, label names, unescaped label
// values, sample and timestamp, each tagged with its token kind and a start
// mark, then one status item per line (0 ok or the first grammar error). An
// item is registered on entry, parsed in the next cycle and its zero, one or
// two results go into a small result queue of Depth entries; one item can be
// taken every cycle while the queue has room for four more results, so the
// sustained rate is one item per cycle as long as the result side drains one
// result per cycle.
module metric_text_line_tokenizer #(
   parameter int unsigned Depth = mtlt_pkg::RSP_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mtlt_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mtlt_pkg::rsp_item_type rsp_item
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [CntW-1:0] Thresh = CntW'(Depth - 4);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

   logic                  stage_valid_ff;
   mtlt_pkg::req_item_type stage_item_ff;

   mtlt_pkg::phase_type phase_ff, phase_in;
   logic                esc_ff, esc_in;
   logic                open_ff, open_in;
   logic [3:0]          err_ff, err_in;

   mtlt_pkg::rsp_item_type queue_ff [Depth];
   logic [PtrW-1:0]        wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in, wr_next;
   logic [CntW-1:0]        count_ff, count_in;

   logic                   n0, n1;
   mtlt_pkg::rsp_item_type res0, res1;
   logic                   pop;

   assign req_stall = (count_ff > Thresh);
   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= req_valid && !req_stall;
      end
      if (req_valid && !req_stall) begin
         stage_item_ff <= req_item;
      end
   end

   // line parser
   always_comb begin
      logic [7:0] c;
      logic       emit_first;
      c          = stage_item_ff.text_byte;
      phase_in   = phase_ff;
      esc_in     = esc_ff;
      open_in    = open_ff;
      err_in     = err_ff;
      n0         = 1'b0;
      n1         = 1'b0;
      res0       = '0;
      res1       = '0;
      emit_first = 1'b0;
      if (stage_valid_ff) begin
         if (stage_item_ff.line_end) begin
            n0               = 1'b1;
            res0.token_kind  = mtlt_pkg::KIND_STATUS;
            res0.last_of_item = 1'b1;
            unique case (phase_ff)
               mtlt_pkg::PH_START:        res0.error_code = mtlt_pkg::ERR_NO_NAME;
               mtlt_pkg::PH_NAME,
               mtlt_pkg::PH_AFTER_NAME:   res0.error_code = mtlt_pkg::ERR_END_NAME;
               mtlt_pkg::PH_LABEL_FIRST:  res0.error_code = mtlt_pkg::ERR_LABEL_START;
               mtlt_pkg::PH_LABEL_NAME,
               mtlt_pkg::PH_WAIT_EQ:      res0.error_code = mtlt_pkg::ERR_NO_EQ;
               mtlt_pkg::PH_WAIT_QUOTE:   res0.error_code = mtlt_pkg::ERR_NO_QUOTE;
               mtlt_pkg::PH_VALUE:        res0.error_code = mtlt_pkg::ERR_END_VALUE;
               mtlt_pkg::PH_AFTER_VALUE:  res0.error_code = mtlt_pkg::ERR_AFTER_VALUE;
               mtlt_pkg::PH_SAMPLE_FIRST: res0.error_code = mtlt_pkg::ERR_NO_SAMPLE;
               mtlt_pkg::PH_ERROR:        res0.error_code = err_ff;
               default:                   res0.error_code = mtlt_pkg::ERR_OK;
            endcase
            phase_in = mtlt_pkg::PH_START;
            esc_in   = 1'b0;
            open_in  = 1'b0;
            err_in   = mtlt_pkg::ERR_OK;
         end else begin
            unique case (phase_ff)
               mtlt_pkg::PH_START: begin
                  if (!mtlt_pkg::is_ws(c)) begin
                     if (mtlt_pkg::is_alpha(c) || c == mtlt_pkg::CH_UNDER ||
                         c == mtlt_pkg::CH_COLON) begin
                        phase_in        = mtlt_pkg::PH_NAME;
                        n0              = 1'b1;
                        res0.token_kind = mtlt_pkg::KIND_NAME;
                     end else begin
                        phase_in = mtlt_pkg::PH_ERROR;
                        err_in   = mtlt_pkg::ERR_NO_NAME;
                     end
                  end
               end
               mtlt_pkg::PH_NAME, mtlt_pkg::PH_AFTER_NAME: begin
                  if (phase_ff == mtlt_pkg::PH_NAME &&
                      (mtlt_pkg::is_alpha(c) || mtlt_pkg::is_digit(c) ||
                       c == mtlt_pkg::CH_UNDER || c == mtlt_pkg::CH_COLON)) begin
                     n0              = 1'b1;
                     res0.token_kind = mtlt_pkg::KIND_NAME;
                  end else begin
                     open_in = 1'b0;
                     if (mtlt_pkg::is_ws(c)) begin
                        phase_in = mtlt_pkg::PH_AFTER_NAME;
                     end else if (c == mtlt_pkg::CH_LBRACE) begin
                        phase_in = mtlt_pkg::PH_LABEL_FIRST;
                     end else if (mtlt_pkg::is_num(c)) begin
                        phase_in        = mtlt_pkg::PH_SAMPLE_IN;
                        n0              = 1'b1;
                        res0.token_kind = mtlt_pkg::KIND_SAMPLE;
                     end else begin
                        phase_in = mtlt_pkg::PH_ERROR;
                        err_in   = mtlt_pkg::ERR_SAMPLE_CHAR;
                     end
                  end
               end
               mtlt_pkg::PH_LABEL_FIRST: begin
                  if (!mtlt_pkg::is_ws(c)) begin
                     if (mtlt_pkg::is_alpha(c) || c == mtlt_pkg::CH_UNDER) begin
                        phase_in        = mtlt_pkg::PH_LABEL_NAME;
                        n0              = 1'b1;
                        res0.token_kind = mtlt_pkg::KIND_LABEL;
                     end else if (c == mtlt_pkg::CH_RBRACE) begin
                        phase_in = mtlt_pkg::PH_SAMPLE_FIRST;
                     end else begin
                        phase_in = mtlt_pkg::PH_ERROR;
                        err_in   = mtlt_pkg::ERR_LABEL_START;
                     end
                  end
               end
               mtlt_pkg::PH_LABEL_NAME: begin
                  if (mtlt_pkg::is_alpha(c) || mtlt_pkg::is_digit(c) ||
                      c == mtlt_pkg::CH_UNDER) begin
                     n0              = 1'b1;
                     res0.token_kind = mtlt_pkg::KIND_LABEL;
                  end else begin
                     open_in = 1'b0;
                     if (mtlt_pkg::is_ws(c)) begin
                        phase_in = mtlt_pkg::PH_WAIT_EQ;
                     end else if (c == mtlt_pkg::CH_EQ) begin
                        phase_in = mtlt_pkg::PH_WAIT_QUOTE;
                     end else begin
                        phase_in = mtlt_pkg::PH_ERROR;
                        err_in   = mtlt_pkg::ERR_NO_EQ;
                     end
                  end
               end
               mtlt_pkg::PH_WAIT_EQ: begin
                  if (!mtlt_pkg::is_ws(c)) begin
                     if (c == mtlt_pkg::CH_EQ) begin
                        phase_in = mtlt_pkg::PH_WAIT_QUOTE;
                     end else begin
                        phase_in = mtlt_pkg::PH_ERROR;
                        err_in   = mtlt_pkg::ERR_NO_EQ;
                     end
                  end
               end
               mtlt_pkg::PH_WAIT_QUOTE: begin
                  if (!mtlt_pkg::is_ws(c)) begin
                     if (c == mtlt_pkg::CH_QUOTE) begin
                        phase_in = mtlt_pkg::PH_VALUE;
                     end else begin
                        phase_in = mtlt_pkg::PH_ERROR;
                        err_in   = mtlt_pkg::ERR_NO_QUOTE;
                     end
                  end
               end
               mtlt_pkg::PH_VALUE: begin
                  if (esc_ff) begin
                     esc_in          = 1'b0;
                     n0              = 1'b1;
                     res0.token_kind = mtlt_pkg::KIND_VALUE;
                     if (c == mtlt_pkg::CH_BSLASH || c == mtlt_pkg::CH_QUOTE) begin
                        emit_first = 1'b0;
                     end else if (c == mtlt_pkg::CH_N) begin
                        emit_first = 1'b1;
                     end else begin
                        n1              = 1'b1;
                        res1.token_kind = mtlt_pkg::KIND_VALUE;
                        res1.out_byte   = c;
                     end
                  end else if (c == mtlt_pkg::CH_BSLASH) begin
                     esc_in = 1'b1;
                  end else if (c == mtlt_pkg::CH_QUOTE) begin
                     open_in  = 1'b0;
                     phase_in = mtlt_pkg::PH_AFTER_VALUE;
                  end else begin
                     n0              = 1'b1;
                     res0.token_kind = mtlt_pkg::KIND_VALUE;
                  end
               end
               mtlt_pkg::PH_AFTER_VALUE: begin
                  if (!mtlt_pkg::is_ws(c)) begin
                     if (c == mtlt_pkg::CH_COMMA) begin
                        phase_in = mtlt_pkg::PH_LABEL_FIRST;
                     end else if (c == mtlt_pkg::CH_RBRACE) begin
                        phase_in = mtlt_pkg::PH_SAMPLE_FIRST;
                     end else begin
                        phase_in = mtlt_pkg::PH_ERROR;
                        err_in   = mtlt_pkg::ERR_AFTER_VALUE;
                     end
                  end
               end
               mtlt_pkg::PH_SAMPLE_FIRST: begin
                  if (!mtlt_pkg::is_ws(c)) begin
                     if (mtlt_pkg::is_num(c)) begin
                        phase_in        = mtlt_pkg::PH_SAMPLE_IN;
                        n0              = 1'b1;
                        res0.token_kind = mtlt_pkg::KIND_SAMPLE;
                     end else begin
                        phase_in = mtlt_pkg::PH_ERROR;
                        err_in   = mtlt_pkg::ERR_SAMPLE_CHAR;
                     end
                  end
               end
               mtlt_pkg::PH_SAMPLE_IN: begin
                  if (mtlt_pkg::is_num(c)) begin
                     n0              = 1'b1;
                     res0.token_kind = mtlt_pkg::KIND_SAMPLE;
                  end else begin
                     open_in = 1'b0;
                     if (mtlt_pkg::is_ws(c)) begin
                        phase_in = mtlt_pkg::PH_TS_WAIT;
                     end else begin
                        phase_in = mtlt_pkg::PH_ERROR;
                        err_in   = mtlt_pkg::ERR_SAMPLE_CHAR;
                     end
                  end
               end
               mtlt_pkg::PH_TS_WAIT: begin
                  if (!mtlt_pkg::is_ws(c)) begin
                     if (mtlt_pkg::is_num(c)) begin
                        phase_in        = mtlt_pkg::PH_TS_IN;
                        n0              = 1'b1;
                        res0.token_kind = mtlt_pkg::KIND_TS;
                     end else if (c == mtlt_pkg::CH_HASH) begin
                        phase_in = mtlt_pkg::PH_DONE;
                     end else begin
                        phase_in = mtlt_pkg::PH_ERROR;
                        err_in   = mtlt_pkg::ERR_TS_CHAR;
                     end
                  end
               end
               mtlt_pkg::PH_TS_IN: begin
                  if (mtlt_pkg::is_num(c)) begin
                     n0              = 1'b1;
                     res0.token_kind = mtlt_pkg::KIND_TS;
                  end else begin
                     open_in = 1'b0;
                     if (mtlt_pkg::is_ws(c) || c == mtlt_pkg::CH_HASH) begin
                        phase_in = mtlt_pkg::PH_DONE;
                     end else begin
                        phase_in = mtlt_pkg::PH_ERROR;
                        err_in   = mtlt_pkg::ERR_TS_CHAR;
                     end
                  end
               end
               default: begin
               end
            endcase
            if (phase_in == mtlt_pkg::PH_ERROR) begin
               open_in = 1'b0;
               esc_in  = 1'b0;
            end
            if (n0) begin
               // token start seen against the open flag after any token close
               res0.token_start  = !open_in;
               res0.last_of_item = !n1;
               if (phase_ff == mtlt_pkg::PH_VALUE && esc_ff) begin
                  res0.out_byte = emit_first ? mtlt_pkg::CH_LF :
                                  (n1 ? mtlt_pkg::CH_BSLASH : c);
               end else begin
                  res0.out_byte = c;
               end
               res1.last_of_item = 1'b1;
               open_in           = 1'b1;
            end
         end
      end
   end

   // result queue
   always_comb begin
      wr_next   = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff;
      if (n0 && n1) begin
         wr_ptr_in = (wr_next == LastPtr) ? '0 : wr_next + 1'b1;
      end else if (n0) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(n0) + CntW'(n1) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= mtlt_pkg::PH_START;
         esc_ff    <= 1'b0;
         open_ff   <= 1'b0;
         err_ff    <= mtlt_pkg::ERR_OK;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         esc_ff    <= esc_in;
         open_ff   <= open_in;
         err_ff    <= err_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (n0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (n1) begin
         queue_ff[wr_next] <= res1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_item_ff.line_end && phase_ff == mtlt_pkg::PH_ERROR
      |-> !n0)
      else $error("result produced after a line error");

   assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> phase_ff == mtlt_pkg::PH_VALUE)
      else $error("escape pending outside a label value");

   assert property (@(posedge clock) disable iff (reset)
      n1 |-> n0 && phase_ff == mtlt_pkg::PH_VALUE && esc_ff)
      else $error("second result outside an escape");

endmodule

>>> tb/tb_metric_text_line_tokenizer.sv
module tb_metric_text_line_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOTAL_ITEMS = 830;
   localparam int QUIET_LIMIT = 1000;
   localparam string NAME_FIRST = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_:";
   localparam string NAME_REST = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_:0123456789";
   localparam string LABEL_FIRST = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   localparam string LABEL_REST = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   localparam string NUM_SET = "0123456789.-+eEINFTYinftyXx";

   class line_token_checker;
      mtlt_pkg::phase_type phase;
      logic esc_pending;
      logic tok_open;
      logic [3:0] line_err;
      mtlt_pkg::rsp_item_type due_tokens[$];
      mtlt_pkg::rsp_item_type fresh[$];
      int mismatches;

      function new();
         clear_state();
         mismatches = 0;
      endfunction

      function void clear_state();
         phase = mtlt_pkg::PH_START;
         esc_pending = 1'b0;
         tok_open = 1'b0;
         line_err = mtlt_pkg::ERR_OK;
      endfunction

      function int pending();
         return due_tokens.size();
      endfunction

      function logic is_blank(logic [7:0] c);
         return c == mtlt_pkg::CH_SPACE || c == mtlt_pkg::CH_TAB;
      endfunction

      function logic is_letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function logic is_decimal(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function logic is_number_char(logic [7:0] c);
         logic hit;
         case (c)
            ".", "-", "+", "e", "E", "I", "N", "F", "T", "Y",
            "i", "n", "f", "t", "y", "X", "x": hit = 1'b1;
            default: hit = is_decimal(c);
         endcase
         return hit;
      endfunction

      function void push_token(logic [2:0] kind, logic [7:0] b);
         mtlt_pkg::rsp_item_type r;
         r = '0;
         r.token_kind = kind;
         r.out_byte = b;
         r.token_start = !tok_open;
         fresh = {fresh, r};
         tok_open = 1'b1;
      endfunction

      function void flag_error(logic [3:0] code);
         phase = mtlt_pkg::PH_ERROR;
         line_err = code;
         tok_open = 1'b0;
         esc_pending = 1'b0;
      endfunction

      function void open_sample(logic [7:0] c);
         if (is_number_char(c)) begin
            phase = mtlt_pkg::PH_SAMPLE_IN;
            push_token(mtlt_pkg::KIND_SAMPLE, c);
         end else begin
            flag_error(mtlt_pkg::ERR_SAMPLE_CHAR);
         end
      endfunction

      function void take_byte(logic [7:0] c);
         case (phase)
            mtlt_pkg::PH_START: begin
               if (!is_blank(c)) begin
                  if (is_letter(c) || c == mtlt_pkg::CH_UNDER || c == mtlt_pkg::CH_COLON) begin
                     phase = mtlt_pkg::PH_NAME;
                     push_token(mtlt_pkg::KIND_NAME, c);
                  end else begin
                     flag_error(mtlt_pkg::ERR_NO_NAME);
                  end
               end
            end
            mtlt_pkg::PH_NAME: begin
               if (is_letter(c) || is_decimal(c) || c == mtlt_pkg::CH_UNDER ||
                   c == mtlt_pkg::CH_COLON) begin
                  push_token(mtlt_pkg::KIND_NAME, c);
               end else begin
                  tok_open = 1'b0;
                  if (is_blank(c)) phase = mtlt_pkg::PH_AFTER_NAME;
                  else if (c == mtlt_pkg::CH_LBRACE) phase = mtlt_pkg::PH_LABEL_FIRST;
                  else open_sample(c);
               end
            end
            mtlt_pkg::PH_AFTER_NAME: begin
               if (!is_blank(c)) begin
                  if (c == mtlt_pkg::CH_LBRACE) phase = mtlt_pkg::PH_LABEL_FIRST;
                  else open_sample(c);
               end
            end
            mtlt_pkg::PH_LABEL_FIRST: begin
               if (!is_blank(c)) begin
                  if (is_letter(c) || c == mtlt_pkg::CH_UNDER) begin
                     phase = mtlt_pkg::PH_LABEL_NAME;
                     push_token(mtlt_pkg::KIND_LABEL, c);
                  end else if (c == mtlt_pkg::CH_RBRACE) begin
                     phase = mtlt_pkg::PH_SAMPLE_FIRST;
                  end else begin
                     flag_error(mtlt_pkg::ERR_LABEL_START);
                  end
               end
            end
            mtlt_pkg::PH_LABEL_NAME: begin
               if (is_letter(c) || is_decimal(c) || c == mtlt_pkg::CH_UNDER) begin
                  push_token(mtlt_pkg::KIND_LABEL, c);
               end else begin
                  tok_open = 1'b0;
                  if (is_blank(c)) phase = mtlt_pkg::PH_WAIT_EQ;
                  else if (c == mtlt_pkg::CH_EQ) phase = mtlt_pkg::PH_WAIT_QUOTE;
                  else flag_error(mtlt_pkg::ERR_NO_EQ);
               end
            end
            mtlt_pkg::PH_WAIT_EQ: begin
               if (!is_blank(c)) begin
                  if (c == mtlt_pkg::CH_EQ) phase = mtlt_pkg::PH_WAIT_QUOTE;
                  else flag_error(mtlt_pkg::ERR_NO_EQ);
               end
            end
            mtlt_pkg::PH_WAIT_QUOTE: begin
               if (!is_blank(c)) begin
                  if (c == mtlt_pkg::CH_QUOTE) phase = mtlt_pkg::PH_VALUE;
                  else flag_error(mtlt_pkg::ERR_NO_QUOTE);
               end
            end
            mtlt_pkg::PH_VALUE: begin
               if (esc_pending) begin
                  esc_pending = 1'b0;
                  if (c == mtlt_pkg::CH_BSLASH || c == mtlt_pkg::CH_QUOTE) begin
                     push_token(mtlt_pkg::KIND_VALUE, c);
                  end else if (c == mtlt_pkg::CH_N) begin
                     push_token(mtlt_pkg::KIND_VALUE, mtlt_pkg::CH_LF);
                  end else begin
                     push_token(mtlt_pkg::KIND_VALUE, mtlt_pkg::CH_BSLASH);
                     push_token(mtlt_pkg::KIND_VALUE, c);
                  end
               end else if (c == mtlt_pkg::CH_BSLASH) begin
                  esc_pending = 1'b1;
               end else if (c == mtlt_pkg::CH_QUOTE) begin
                  tok_open = 1'b0;
                  phase = mtlt_pkg::PH_AFTER_VALUE;
               end else begin
                  push_token(mtlt_pkg::KIND_VALUE, c);
               end
            end
            mtlt_pkg::PH_AFTER_VALUE: begin
               if (!is_blank(c)) begin
                  if (c == mtlt_pkg::CH_COMMA) phase = mtlt_pkg::PH_LABEL_FIRST;
                  else if (c == mtlt_pkg::CH_RBRACE) phase = mtlt_pkg::PH_SAMPLE_FIRST;
                  else flag_error(mtlt_pkg::ERR_AFTER_VALUE);
               end
            end
            mtlt_pkg::PH_SAMPLE_FIRST: begin
               if (!is_blank(c)) open_sample(c);
            end
            mtlt_pkg::PH_SAMPLE_IN: begin
               if (is_number_char(c)) begin
                  push_token(mtlt_pkg::KIND_SAMPLE, c);
               end else begin
                  tok_open = 1'b0;
                  if (is_blank(c)) phase = mtlt_pkg::PH_TS_WAIT;
                  else flag_error(mtlt_pkg::ERR_SAMPLE_CHAR);
               end
            end
            mtlt_pkg::PH_TS_WAIT: begin
               if (!is_blank(c)) begin
                  if (is_number_char(c)) begin
                     phase = mtlt_pkg::PH_TS_IN;
                     push_token(mtlt_pkg::KIND_TS, c);
                  end else if (c == mtlt_pkg::CH_HASH) begin
                     phase = mtlt_pkg::PH_DONE;
                  end else begin
                     flag_error(mtlt_pkg::ERR_TS_CHAR);
                  end
               end
            end
            mtlt_pkg::PH_TS_IN: begin
               if (is_number_char(c)) begin
                  push_token(mtlt_pkg::KIND_TS, c);
               end else begin
                  tok_open = 1'b0;
                  if (is_blank(c) || c == mtlt_pkg::CH_HASH) phase = mtlt_pkg::PH_DONE;
                  else flag_error(mtlt_pkg::ERR_TS_CHAR);
               end
            end
            default: begin
            end
         endcase
      endfunction

      function logic [3:0] line_status();
         case (phase)
            mtlt_pkg::PH_START: return mtlt_pkg::ERR_NO_NAME;
            mtlt_pkg::PH_NAME, mtlt_pkg::PH_AFTER_NAME: return mtlt_pkg::ERR_END_NAME;
            mtlt_pkg::PH_LABEL_FIRST: return mtlt_pkg::ERR_LABEL_START;
            mtlt_pkg::PH_LABEL_NAME, mtlt_pkg::PH_WAIT_EQ: return mtlt_pkg::ERR_NO_EQ;
            mtlt_pkg::PH_WAIT_QUOTE: return mtlt_pkg::ERR_NO_QUOTE;
            mtlt_pkg::PH_VALUE: return mtlt_pkg::ERR_END_VALUE;
            mtlt_pkg::PH_AFTER_VALUE: return mtlt_pkg::ERR_AFTER_VALUE;
            mtlt_pkg::PH_SAMPLE_FIRST: return mtlt_pkg::ERR_NO_SAMPLE;
            mtlt_pkg::PH_ERROR: return line_err;
            default: return mtlt_pkg::ERR_OK;
         endcase
      endfunction

      function void note_item(mtlt_pkg::req_item_type it);
         mtlt_pkg::rsp_item_type r;
         fresh.delete();
         if (it.line_end) begin
            r = '0;
            r.token_kind = mtlt_pkg::KIND_STATUS;
            r.error_code = line_status();
            fresh = {fresh, r};
            clear_state();
         end else begin
            take_byte(it.text_byte);
         end
         if (fresh.size() > 0) fresh[fresh.size() - 1].last_of_item = 1'b1;
         due_tokens = {due_tokens, fresh};
      endfunction

      function void check_token(mtlt_pkg::rsp_item_type got);
         mtlt_pkg::rsp_item_type want;
         if (due_tokens.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected token: kind %0d byte %02h start %0b err %0d last %0b",
                        got.token_kind, got.out_byte, got.token_start, got.error_code,
                        got.last_of_item);
            mismatches++;
            return;
         end
         want = due_tokens.pop_front();
         if (got.token_kind !== want.token_kind || got.out_byte !== want.out_byte ||
             got.token_start !== want.token_start || got.error_code !== want.error_code ||
             got.last_of_item !== want.last_of_item) begin
            if (mismatches < 10)
               $display("token mismatch: expected %0d/%02h/%0b/%0d/%0b got %0d/%02h/%0b/%0d/%0b",
                        want.token_kind, want.out_byte, want.token_start, want.error_code,
                        want.last_of_item, got.token_kind, got.out_byte, got.token_start,
                        got.error_code, got.last_of_item);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   mtlt_pkg::req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mtlt_pkg::rsp_item_type rsp_item;

   line_token_checker checker_q = new();
   logic [7:0] line_buf[$];
   int items_sent = 0;
   bit idle_on = 1'b1;
   int stall_left = 0;

   metric_text_line_tokenizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) checker_q.note_item(req_item);
         if (rsp_valid && !rsp_stall) checker_q.check_token(rsp_item);
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [7:0] pick(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   task automatic put_byte(input logic [7:0] b);
      line_buf = {line_buf, b};
   endtask

   task automatic send_item(input logic [7:0] b, input logic e);
      int gap;
      mtlt_pkg::req_item_type it;
      it.text_byte = b;
      it.line_end = e;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic add_blanks(input int lo, input int hi);
      int n;
      n = $urandom_range(lo, hi);
      repeat (n) put_byte($urandom_range(0, 1) ? mtlt_pkg::CH_SPACE : mtlt_pkg::CH_TAB);
   endtask

   task automatic add_word(input string first_set, input string rest_set, input int max_len);
      int n;
      n = $urandom_range(1, max_len);
      put_byte(pick(first_set));
      repeat (n - 1) put_byte(pick(rest_set));
   endtask

   task automatic add_value();
      int n;
      logic [7:0] c;
      n = $urandom_range(0, 5);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0) begin
            put_byte(mtlt_pkg::CH_BSLASH);
            case ($urandom_range(0, 3))
               0: put_byte(mtlt_pkg::CH_BSLASH);
               1: put_byte(mtlt_pkg::CH_QUOTE);
               2: put_byte(mtlt_pkg::CH_N);
               default: put_byte(8'($urandom_range(0, 255)));
            endcase
         end else begin
            c = 8'($urandom_range(0, 255));
            if (c == mtlt_pkg::CH_QUOTE || c == mtlt_pkg::CH_BSLASH) c = "v";
            put_byte(c);
         end
      end
   endtask

   task automatic build_line();
      int labels;
      int pos;
      line_buf.delete();
      if ($urandom_range(0, 9) == 0) begin
         // plain noise
         repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 4) == 0) add_blanks(1, 2);
         add_word(NAME_FIRST, NAME_REST, 6);
         if ($urandom_range(0, 2) != 0) begin
            put_byte(mtlt_pkg::CH_LBRACE);
            labels = $urandom_range(0, 3);
            for (int i = 0; i < labels; i++) begin
               if (i > 0) put_byte(mtlt_pkg::CH_COMMA);
               add_blanks(0, 1);
               add_word(LABEL_FIRST, LABEL_REST, 5);
               add_blanks(0, 1);
               put_byte(mtlt_pkg::CH_EQ);
               add_blanks(0, 1);
               put_byte(mtlt_pkg::CH_QUOTE);
               add_value();
               put_byte(mtlt_pkg::CH_QUOTE);
               add_blanks(0, 1);
            end
            if (labels > 0 && $urandom_range(0, 3) == 0) put_byte(mtlt_pkg::CH_COMMA);
            put_byte(mtlt_pkg::CH_RBRACE);
            add_blanks(0, 2);
         end else begin
            add_blanks(1, 2);
         end
         if ($urandom_range(0, 9) != 0) begin
            add_word(NUM_SET, NUM_SET, 5);
            if ($urandom_range(0, 1) != 0) begin
               add_blanks(1, 2);
               add_word(NUM_SET, NUM_SET, 5);
               case ($urandom_range(0, 2))
                  1: begin
                     add_blanks(0, 1);
                     put_byte(mtlt_pkg::CH_HASH);
                     repeat ($urandom_range(0, 3))
                        put_byte(8'($urandom_range(0, 255)));
                  end
                  2: begin
                     add_blanks(1, 1);
                     repeat ($urandom_range(1, 3))
                        put_byte(8'($urandom_range(0, 255)));
                  end
                  default: begin
                  end
               endcase
            end else if ($urandom_range(0, 3) == 0) begin
               add_blanks(1, 1);
               put_byte(mtlt_pkg::CH_HASH);
            end
         end
         // broken lines: one byte replaced or the tail cut off
         if ($urandom_range(0, 3) == 0 && line_buf.size() > 0) begin
            pos = $urandom_range(0, line_buf.size() - 1);
            if ($urandom_range(0, 1) != 0) line_buf[pos] = 8'($urandom_range(0, 255));
            else while (line_buf.size() > pos) void'(line_buf.pop_back());
         end
      end
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      bit paused;
      paused = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty line, comment line, name running into the sample
      line_buf.delete();
      send_line();
      line_buf.delete();
      append_text("#");
      send_line();
      line_buf.delete();
      append_text("x.");
      send_line();
      // escapes, high and zero bytes, trailing comma, missing sample
      line_buf.delete();
      append_text("_{a=\"\\\\\\\"\\n\\q");
      put_byte(8'hFF);
      put_byte(8'h00);
      append_text("\",}");
      send_line();
      // hash where the timestamp could start
      line_buf.delete();
      append_text("b 1 #");
      send_line();

      while (items_sent < TOTAL_ITEMS) begin
         idle_on = (items_sent < TOTAL_ITEMS * 7 / 8) && ($urandom_range(0, 4) != 0);
         if (!paused && items_sent > TOTAL_ITEMS / 2) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (checker_q.pending() != 0) @(posedge clock);
         end
         build_line();
         send_line();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (checker_q.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (checker_q.mismatches == 0 && checker_q.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
